// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int BYTE_W      = 8;
   localparam int OP_W        = 2;
   localparam int CSR_INDEX_W = 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
   localparam logic [OP_W-1:0] OP_FILL = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_CODE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_COLOR = 1'd1;

   // character codes
   localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;

   localparam logic [BYTE_W-1:0] ESCAPE_CODE_RESET   = 8'd27;
   localparam logic [BYTE_W-1:0] DEFAULT_COLOR_RESET = 8'd7;

   // how the datapath will finish the item held for execution
   localparam logic [1:0] KIND_SIMPLE = 2'd0;
   localparam logic [1:0] KIND_SWEEP  = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   typedef logic [2*BYTE_W-1:0] cell_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] data_byte;
      logic [COL_W-1:0]  read_col;
      logic [ROW_W-1:0]  read_row;
   } req_payload_type;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic [BYTE_W-1:0] active_color;
      logic [BYTE_W-1:0] cell_char;
      logic [BYTE_W-1:0] cell_color;
      logic              scrolled;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic sweep_step;
      logic load_rsp;
   } tcw_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       out_free;
      logic       scan_last;
   } tcw_status_type;

endpackage

`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: clearing pass, item accept, execute, screen sweeps, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  tcw_status_type status,
   output tcw_cmd_type    cmd
);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_CLEAR_END = 3'd1;
   localparam logic [2:0] S_IDLE      = 3'd2;
   localparam logic [2:0] S_EXEC      = 3'd3;
   localparam logic [2:0] S_SWEEP     = 3'd4;
   localparam logic [2:0] S_SWEEP_END = 3'd5;
   localparam logic [2:0] S_READ      = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_CLEAR_END;
            end
         end
         S_CLEAR_END: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the result register can take a beat
            if (status.out_free) begin
               cmd.exec = 1'b1;
               case (status.kind)
                  KIND_SWEEP: begin
                     state_in = S_SWEEP;
                  end
                  KIND_READ: begin
                     state_in = S_READ;
                  end
                  default: begin
                     cmd.load_rsp = 1'b1;
                     state_in     = S_IDLE;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.scan_last) begin
               state_in = S_SWEEP_END;
            end
         end
         S_SWEEP_END: begin
            cmd.load_rsp = 1'b1;
            state_in     = S_IDLE;
         end
         S_READ: begin
            cmd.load_rsp = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor and colour state, screen memory with its sweep counter, result
// register and the escape code register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tcw_cmd_type            cmd,
   output tcw_status_type         status,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_data
);

   localparam int NCELLS = COLUMNS * ROWS;
   localparam int AW     = $clog2(NCELLS);
   localparam int XW     = $clog2(COLUMNS);
   localparam int YW     = $clog2(ROWS);

   localparam logic [AW-1:0] COPY_END  = AW'(NCELLS - COLUMNS);
   localparam logic [AW-1:0] SCAN_LAST = AW'(NCELLS - 1);
   localparam logic [XW-1:0] X_LAST    = XW'(COLUMNS - 1);
   localparam logic [YW-1:0] Y_LAST    = YW'(ROWS - 1);

   localparam logic [1:0] SWEEP_ZERO   = 2'd0;
   localparam logic [1:0] SWEEP_SCROLL = 2'd1;
   localparam logic [1:0] SWEEP_FILL   = 2'd2;

   logic [XW-1:0]     x_ff, x_in;
   logic [YW-1:0]     y_ff, y_in;
   logic [BYTE_W-1:0] color_ff, color_in;
   logic              esc_pend_ff, esc_pend_in;
   logic [BYTE_W-1:0] escape_code_ff, escape_code_in;
   req_payload_type   item_ff;
   logic [1:0]        sweep_kind_ff, sweep_kind_in;
   logic [BYTE_W-1:0] fill_color_ff, fill_color_in;
   logic [AW-1:0]     scan_ff, scan_in;
   logic              oob_ff, oob_in;
   logic              wr_valid_ff, wr_valid_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   cell_type          wr_data_ff, wr_data_in;
   logic              wr_copy_ff, wr_copy_in;
   cell_type          rdata_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;

   cell_type          screen_ff [NCELLS];

   logic [BYTE_W-1:0] put_byte;
   logic              put_op;
   logic              is_nul, is_esc, is_ctl, is_nl, is_cr, is_bs, is_print;
   logic              x_last, y_last, line_feed, need_scroll;
   logic              read_oob, copy_read;
   logic [AW-1:0]     cursor_addr, read_addr, rd_addr;

   // ---- decode of the held item ----
   assign put_op   = (item_ff.operation == OP_PUT);
   assign put_byte = item_ff.data_byte;
   assign is_nul   = (put_byte == CHAR_NUL);
   assign is_esc   = !is_nul && !esc_pend_ff && (put_byte == escape_code_ff);
   assign is_ctl   = !is_nul && !esc_pend_ff && !is_esc;
   assign is_nl    = is_ctl && (put_byte == CHAR_NEWLINE);
   assign is_cr    = is_ctl && (put_byte == CHAR_RETURN);
   assign is_bs    = is_ctl && (put_byte == CHAR_BACKSPACE);
   assign is_print = is_ctl && !is_nl && !is_cr && !is_bs;

   assign x_last      = (x_ff == X_LAST);
   assign y_last      = (y_ff == Y_LAST);
   assign line_feed   = put_op && (is_nl || (is_print && x_last));
   assign need_scroll = line_feed && y_last;

   assign cursor_addr = AW'(y_ff) * AW'(COLUMNS) + AW'(x_ff);
   assign read_oob    = (32'(item_ff.read_col) >= COLUMNS) ||
                        (32'(item_ff.read_row) >= ROWS);
   assign read_addr   = read_oob ? '0 :
                        AW'(item_ff.read_row) * AW'(COLUMNS) + AW'(item_ff.read_col);

   // scroll reads one row ahead of the cell it rewrites
   assign copy_read = cmd.sweep_step && (sweep_kind_ff == SWEEP_SCROLL) &&
                      (scan_ff < COPY_END);
   assign rd_addr   = copy_read ? (scan_ff + AW'(COLUMNS)) : read_addr;

   always_comb begin
      unique case (item_ff.operation)
         OP_PUT:  status.kind = need_scroll ? KIND_SWEEP : KIND_SIMPLE;
         OP_FILL: status.kind = KIND_SWEEP;
         OP_READ: status.kind = KIND_READ;
         default: status.kind = KIND_SIMPLE;
      endcase
      status.out_free  = !rsp_valid_ff || !rsp_stall;
      status.scan_last = (scan_ff == SCAN_LAST);
   end

   // ---- next state ----
   always_comb begin
      x_in           = x_ff;
      y_in           = y_ff;
      color_in       = color_ff;
      esc_pend_in    = esc_pend_ff;
      escape_code_in = escape_code_ff;
      sweep_kind_in  = sweep_kind_ff;
      fill_color_in  = fill_color_ff;
      scan_in        = scan_ff;
      oob_in         = oob_ff;
      wr_valid_in    = 1'b0;
      wr_addr_in     = wr_addr_ff;
      wr_data_in     = wr_data_ff;
      wr_copy_in     = wr_copy_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_ESCAPE_CODE: begin
               escape_code_in = csr_data;
            end
            CSR_DEFAULT_COLOR: begin
               // reset restores this register too, so nothing to keep
            end
            default: begin
            end
         endcase
      end

      if (cmd.exec) begin
         unique case (item_ff.operation)
            OP_PUT: begin
               if (is_nul) begin
                  esc_pend_in = 1'b0;
               end else if (esc_pend_ff) begin
                  color_in    = put_byte;
                  esc_pend_in = 1'b0;
               end else if (is_esc) begin
                  esc_pend_in = 1'b1;
               end else if (line_feed) begin
                  x_in = '0;
                  if (!y_last) begin
                     y_in = y_ff + 1'b1;
                  end
               end else if (is_cr) begin
                  x_in = '0;
               end else if (is_bs) begin
                  if (x_ff != '0) begin
                     x_in = x_ff - 1'b1;
                  end
               end else begin
                  x_in = x_ff + 1'b1;
               end
               if (is_print) begin
                  wr_valid_in = 1'b1;
                  wr_addr_in  = cursor_addr;
                  wr_data_in  = {color_ff, put_byte};
                  wr_copy_in  = 1'b0;
               end
               if (need_scroll) begin
                  sweep_kind_in = SWEEP_SCROLL;
                  scan_in       = '0;
               end
            end
            OP_FILL: begin
               x_in          = '0;
               y_in          = '0;
               fill_color_in = put_byte;
               sweep_kind_in = SWEEP_FILL;
               scan_in       = '0;
            end
            OP_READ: begin
               oob_in = read_oob;
            end
            default: begin
            end
         endcase
      end

      if (cmd.sweep_step) begin
         wr_valid_in = 1'b1;
         wr_addr_in  = scan_ff;
         wr_copy_in  = copy_read;
         wr_data_in  = (sweep_kind_ff == SWEEP_FILL) ? {fill_color_ff, CHAR_SPACE} : '0;
         scan_in     = scan_ff + 1'b1;
      end

      if (cmd.load_rsp) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.cursor_col   = COL_W'(x_in);
         rsp_payload_in.cursor_row   = ROW_W'(y_in);
         rsp_payload_in.active_color = color_in;
         if ((item_ff.operation == OP_READ) && !oob_ff) begin
            rsp_payload_in.cell_char  = rdata_ff[BYTE_W-1:0];
            rsp_payload_in.cell_color = rdata_ff[2*BYTE_W-1:BYTE_W];
         end else begin
            rsp_payload_in.cell_char  = '0;
            rsp_payload_in.cell_color = '0;
         end
         // a put finishes outside execute only after a scroll
         rsp_payload_in.scrolled = put_op && !cmd.exec;
      end
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff           <= '0;
         y_ff           <= '0;
         color_ff       <= DEFAULT_COLOR_RESET;
         esc_pend_ff    <= 1'b0;
         escape_code_ff <= ESCAPE_CODE_RESET;
         sweep_kind_ff  <= SWEEP_ZERO;
         scan_ff        <= '0;
         wr_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         x_ff           <= x_in;
         y_ff           <= y_in;
         color_ff       <= color_in;
         esc_pend_ff    <= esc_pend_in;
         escape_code_ff <= escape_code_in;
         sweep_kind_ff  <= sweep_kind_in;
         scan_ff        <= scan_in;
         wr_valid_ff    <= wr_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_payload;
      end
      fill_color_ff  <= fill_color_in;
      oob_ff         <= oob_in;
      wr_addr_ff     <= wr_addr_in;
      wr_data_ff     <= wr_data_in;
      wr_copy_ff     <= wr_copy_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // ---- screen memory: one write port, one registered read port ----
   always_ff @(posedge clock) begin
      if (wr_valid_ff) begin
         screen_ff[wr_addr_ff] <= wr_copy_ff ? rdata_ff : wr_data_ff;
      end
      rdata_ff <= screen_ff[rd_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== rtl/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console over a COLUMNS x ROWS screen memory of colour/char cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per operation (put byte, fill screen, read cell),
//            taken when req_valid is high and req_stall is low.
//   rsp_*  : exactly one result beat per request, in order, showing the
//            cursor and colour after the item plus the read cell.
//   csr_*  : register writes (escape code, default colour); csr_ready is
//            always high. Write only while the block is idle.
// Steps per operation:
//   put without scroll, unused operation : accept, execute.
//   read cell                            : accept, execute, memory read.
//   fill, or put that scrolls            : accept, execute, sweep, sweep end;
//            the sweep writes one cell per cycle via the single write port.
//   A result appears the cycle after the item's last cycle; the next beat
//   may be accepted while it still waits in the result register.
// Reset: synchronous. Afterwards a clearing pass zeroes every screen cell
//   with req_stall held high; csr writes are taken as ever.
// Receiver stall: the result register holds its beat; the next item is still
//   accepted but waits in execute until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_data
);

   tcw_cmd_type    cmd;
   tcw_status_type status;
   logic           csr_write;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // sequencer: owns the state machine and raises the commands
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: cursor, colour, screen memory and result register
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // the clearing pass follows every reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken before the clearing pass");

   // one item at a time: an accepted beat is followed by a stalled cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted back to back");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((32'(rsp_payload.cursor_col) < COLUMNS) &&
                     (32'(rsp_payload.cursor_row) < ROWS)))
      else $error("result cursor outside the screen");

   // a scroll leaves the cursor at the start of the bottom row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.scrolled) |->
         ((rsp_payload.cursor_col == '0) &&
          (rsp_payload.cursor_row == ROW_W'(ROWS - 1))))
      else $error("scroll result with cursor off the bottom row start");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result beat changed");

endmodule

bind text_console_writer_core tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== sim/text_console_writer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// Self-checking bench for the text console writer.
// ----------------------------------------------------------------------------
// A queue of operations (put byte, fill, read cell, unused code) feeds a
// clocked driver on the req channel. Each accepted beat is run through a
// local copy of the console (cursor, colour, escape flag, screen cells)
// and the cursor/colour/cell view it yields is queued. A clocked monitor
// on the rsp channel pops the oldest view and compares it field by field.
// A short directed burst opens the run, then six random phases follow,
// each with its own escape code and default colour, one of four idling patterns.
// ----------------------------------------------------------------------------

module text_console_writer_core_tb;
   import tcw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int PHASE_BEATS = 300;
   // A fill or a scrolling put costs a pass over the screen; even a run
   // made only of those stays well inside this bound.
   localparam int CYCLE_LIMIT = 20_000_000;
   // The one operation code that the package leaves unnamed.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]      csr_data = '0;

   // Operations waiting to be driven, and the console views they will yield.
   req_payload_type console_ops[$];
   rsp_payload_type console_views[$];

   // Local copy of the console state and registers.
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic [BYTE_W-1:0] cur_colour;
   logic              esc_armed;
   logic [BYTE_W-1:0] esc_code;
   logic [BYTE_W-1:0] reset_colour;
   cell_type          screen_copy [COLUMNS*ROWS];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int fault_count = 0;
   int cycle_count = 0;

   text_console_writer_core #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Console copy
   // ------------------------------------------------------------------------

   // Drop to column 0 of the next row; on the bottom row shift every row up
   // and blank the last one instead. Returns 1 when the screen scrolled.
   function automatic logic next_row();
      int idx;
      cur_col = '0;
      if (cur_row == ROWS - 1) begin
         for (idx = 0; idx < (ROWS - 1) * COLUMNS; idx++)
            screen_copy[idx] = screen_copy[idx + COLUMNS];
         for (idx = (ROWS - 1) * COLUMNS; idx < ROWS * COLUMNS; idx++)
            screen_copy[idx] = '0;
         return 1'b1;
      end
      cur_row++;
      return 1'b0;
   endfunction

   // Apply one operation to the console copy and return the view it leaves.
   function automatic rsp_payload_type console_step(input req_payload_type op);
      rsp_payload_type view;
      int idx;
      view = '0;
      case (op.operation)
         OP_PUT: begin
            // Order matters: NUL first, then a pending escape, then the escape
            // byte itself, and only then the control characters.
            if (op.data_byte == CHAR_NUL) begin
               esc_armed = 1'b0;
            end else if (esc_armed) begin
               cur_colour = op.data_byte;
               esc_armed = 1'b0;
            end else if (op.data_byte == esc_code) begin
               esc_armed = 1'b1;
            end else if (op.data_byte == CHAR_NEWLINE) begin
               view.scrolled = next_row();
            end else if (op.data_byte == CHAR_RETURN) begin
               cur_col = '0;
            end else if (op.data_byte == CHAR_BACKSPACE) begin
               if (cur_col > 0)
                  cur_col--;
            end else begin
               screen_copy[int'(cur_row) * COLUMNS + int'(cur_col)] =
                  {cur_colour, op.data_byte};
               cur_col++;
               // wrap at the line end, which may scroll as a newline does
               if (cur_col >= COLUMNS)
                  view.scrolled = next_row();
            end
         end
         OP_FILL: begin
            for (idx = 0; idx < ROWS * COLUMNS; idx++)
               screen_copy[idx] = {op.data_byte, CHAR_SPACE};
            cur_col = '0;
            cur_row = '0;
         end
         OP_READ: begin
            // out-of-range coordinates read as an all-zero cell
            if (op.read_col < COLUMNS && op.read_row < ROWS)
               {view.cell_color, view.cell_char} =
                  screen_copy[int'(op.read_row) * COLUMNS + int'(op.read_col)];
         end
         default: ;
      endcase
      view.cursor_col   = cur_col;
      view.cursor_row   = cur_row;
      view.active_color = cur_colour;
      return view;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic draw_gap(input int pct);
      return pct > 0 && $urandom_range(99) < pct;
   endfunction

   task automatic queue_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                           input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      req_payload_type beat;
      beat.operation = op;
      beat.data_byte = data;
      beat.read_col  = col;
      beat.read_row  = row;
      console_ops.push_back(beat);
   endtask

   // Put a byte; the unused coordinate fields carry noise.
   task automatic queue_put(input logic [BYTE_W-1:0] b);
      queue_op(OP_PUT, b, COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
   endtask

   // Write one register. Hold valid until the beat is taken, then keep it
   // low for a cycle so that back-to-back calls never clash in one step.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [BYTE_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      // the block is idle, so the copy can take the new value right here
      if (idx == CSR_ESCAPE_CODE)
         esc_code = value;
      else
         reset_colour = value; // only used at reset, which never recurs
      @(posedge clock);
   endtask

   // One random stretch of traffic. Mostly text and line control, with
   // colour escapes, reads, the odd fill and some deliberately broken bits.
   task automatic queue_random_stretch();
      int pick;
      int len;
      int k;
      pick = $urandom_range(999);
      if (pick < 550) begin
         if ($urandom_range(4) == 0)
            queue_put(BYTE_W'($urandom_range(255)));
         else
            queue_put(BYTE_W'($urandom_range(32, 255)));
      end else if (pick < 600) begin
         // a long run of text, enough to wrap the line now and then
         len = $urandom_range(1, 90);
         for (k = 0; k < len; k++)
            queue_put(BYTE_W'($urandom_range(32, 255)));
      end else if (pick < 660) begin
         queue_put(CHAR_NEWLINE);
      end else if (pick < 690) begin
         queue_put(CHAR_RETURN);
      end else if (pick < 720) begin
         queue_put(CHAR_BACKSPACE);
      end else if (pick < 740) begin
         queue_put(CHAR_NUL);
      end else if (pick < 800) begin
         // colour escape; now and then cancelled by NUL or doubled
         queue_put(esc_code);
         case ($urandom_range(9))
            0:       queue_put(CHAR_NUL);
            1:       queue_put(esc_code);
            default: queue_put(BYTE_W'($urandom_range(255)));
         endcase
      end else if (pick < 815) begin
         // a burst of newlines can drive the cursor to the bottom and scroll
         len = $urandom_range(1, 30);
         for (k = 0; k < len; k++)
            queue_put(CHAR_NEWLINE);
      end else if (pick < 950) begin
         if ($urandom_range(9) == 0)
            queue_op(OP_READ, BYTE_W'($urandom_range(255)),
                     COL_W'($urandom_range(127)), ROW_W'($urandom_range(31)));
         else
            queue_op(OP_READ, BYTE_W'($urandom_range(255)),
                     COL_W'($urandom_range(COLUMNS - 1)),
                     ROW_W'($urandom_range(ROWS - 1)));
      end else if (pick < 953) begin
         queue_op(OP_FILL, BYTE_W'($urandom_range(255)), COL_W'($urandom_range(127)),
                  ROW_W'($urandom_range(31)));
      end else if (pick < 965) begin
         queue_op(OP_UNUSED, BYTE_W'($urandom_range(255)), COL_W'($urandom_range(127)),
                  ROW_W'($urandom_range(31)));
      end else begin
         queue_put(BYTE_W'($urandom_range(255)));
      end
   endtask

   // Block until every queued operation has been driven and answered. Judge
   // at the falling edge, when the driver's updates have settled, and return
   // on the next rising edge.
   task automatic drain();
      @(negedge clock);
      while (console_ops.size() != 0 || req_valid || console_views.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Driver: present the next operation whenever the slot is free
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // a beat held here now is taken at this edge: predict its view
         if (req_valid)
            console_views.push_back(console_step(req_payload));
         if (console_ops.size() != 0 && !draw_gap(sender_idle_pct)) begin
            req_payload <= console_ops.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: compare each result beat against the oldest predicted view
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (console_views.size() == 0) begin
               $error("result beat with no view awaited");
               fault_count++;
            end else begin
               want = console_views.pop_front();
               check_field("cursor_col", int'(want.cursor_col),
                           int'(rsp_payload.cursor_col));
               check_field("cursor_row", int'(want.cursor_row),
                           int'(rsp_payload.cursor_row));
               check_field("active_color", int'(want.active_color),
                           int'(rsp_payload.active_color));
               check_field("cell_char", int'(want.cell_char),
                           int'(rsp_payload.cell_char));
               check_field("cell_color", int'(want.cell_color),
                           int'(rsp_payload.cell_color));
               check_field("scrolled", int'(want.scrolled),
                           int'(rsp_payload.scrolled));
            end
         end
         rsp_stall <= draw_gap(receiver_stall_pct);
      end
   end

   // Watchdog: abandon a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: reset, directed burst, random phases, final drain
   // ------------------------------------------------------------------------
   initial begin
      int phase;
      int idx;
      int first_len;
      logic [BYTE_W-1:0] esc_setting;
      logic [BYTE_W-1:0] colour_setting;

      // console copy as it stands after reset
      cur_col      = '0;
      cur_row      = '0;
      cur_colour   = DEFAULT_COLOR_RESET;
      esc_armed    = 1'b0;
      esc_code     = ESCAPE_CODE_RESET;
      reset_colour = DEFAULT_COLOR_RESET;
      for (idx = 0; idx < ROWS * COLUMNS; idx++)
         screen_copy[idx] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed burst under reset register values, no idling.
      queue_op(OP_READ, 8'h00, 7'd0, 5'd0);             // cleared screen
      queue_put(8'h41);
      queue_put(8'hFF);                                  // top-bit bytes stay unsigned
      queue_put(8'h80);
      queue_put(ESCAPE_CODE_RESET);                      // colour change
      queue_put(8'h1F);
      queue_put(ESCAPE_CODE_RESET);                      // escape cancelled by NUL
      queue_put(CHAR_NUL);
      queue_put(8'h42);
      queue_put(CHAR_BACKSPACE);
      queue_put(CHAR_RETURN);
      queue_put(CHAR_BACKSPACE);                         // already at column 0
      queue_put(CHAR_NEWLINE);
      queue_op(OP_READ, 8'hFF, 7'd0, 5'd0);
      queue_op(OP_READ, 8'h00, 7'd1, 5'd0);
      queue_op(OP_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
      queue_op(OP_READ, 8'h00, COL_W'(COLUMNS), 5'd0);  // column out of range
      queue_op(OP_READ, 8'h00, 7'd0, ROW_W'(ROWS));     // row out of range
      queue_op(OP_READ, 8'h00, 7'd127, 5'd31);
      queue_op(OP_UNUSED, 8'hFF, 7'd127, 5'd31);
      queue_op(OP_FILL, 8'hFF, 7'd0, 5'd0);
      queue_op(OP_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
      queue_put(ESCAPE_CODE_RESET);                      // escape byte taken as colour
      queue_put(ESCAPE_CODE_RESET);
      queue_op(OP_FILL, 8'h00, 7'd127, 5'd31);
      drain();
      repeat (4) @(posedge clock);

      // Random phases: each one sets the registers while idle, picks an
      // idling pattern and then runs a batch of random stretches.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin esc_setting = ESCAPE_CODE_RESET; colour_setting = 8'h00; end
            1: begin esc_setting = 8'h00;             colour_setting = 8'hFF; end
            2: begin esc_setting = 8'hFF;             colour_setting = 8'h5A; end
            3: begin esc_setting = CHAR_NEWLINE;      colour_setting = 8'hA5; end
            4: begin
               esc_setting    = CHAR_BACKSPACE;
               colour_setting = BYTE_W'($urandom_range(255));
            end
            default: begin
               esc_setting    = BYTE_W'($urandom_range(255));
               colour_setting = BYTE_W'($urandom_range(255));
            end
         endcase
         write_csr(CSR_ESCAPE_CODE, esc_setting);
         write_csr(CSR_DEFAULT_COLOR, colour_setting);

         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase

         first_len = console_ops.size();
         idx = 0;
         while (idx < PHASE_BEATS) begin
            first_len = console_ops.size();
            queue_random_stretch();
            idx += console_ops.size() - first_len;
            // let the driver keep pace so the queue never grows large
            if (console_ops.size() > 64)
               @(posedge clock);
         end
         drain();
         repeat (4) @(posedge clock);
      end

      // Allow for the slowest operation, a full pass over the screen.
      repeat (COLUMNS * ROWS + 100) @(posedge clock);

      if (fault_count == 0 && console_views.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
